@@ hw/rtl/npve_pkg.sv @@
// ----------------------------------------------------------------------------
// npve_pkg: shared types and constants of the NED pose velocity estimator
// Field widths, the nanoseconds-per-second scale and the lane result record.
// ----------------------------------------------------------------------------
package npve_pkg;

    localparam int POS_W    = 32;
    localparam int QUAT_W   = 16;
    localparam int SEC_W    = 32;
    localparam int NSEC_W   = 30;
    localparam int TIME_W   = 64;
    localparam int NUM_AXES = 3;

    localparam logic [NSEC_W-1:0] NS_PER_SEC = 30'd1000000000;

    typedef struct packed {
        logic             done;
        logic [POS_W-1:0] vel;
    } t_lane_res;

endpackage

@@ hw/rtl/ned_pose_velocity_estimator_top.sv @@
// ----------------------------------------------------------------------------
// ned_pose_velocity_estimator_top: NED pose conversion and velocity estimate
// One tracker frame in, one converted pose with velocity out. After the input
// transfer the frame passes the multiply, sum and compare states. When the
// position differs from the oldest ring entry and the stamp is later than its
// stamp, the velocity is recomputed by the 64-step bit-serial divider in each
// of the three axis lanes, which run side by side; else the last velocity is
// held. The result is then loaded into the output register. A new frame is
// taken once the previous one has been handed to the output register, which
// may still be waiting for the downstream side. The position ring holds WINDOW
// entries and starts as zero.
// ----------------------------------------------------------------------------
module ned_pose_velocity_estimator_top #(
    parameter int WINDOW = 3
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z, stamp_sec,
    // stamp_nsec, two zero bits.
    input  logic [223:0] i_s_axis_tdata,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // ned_x, ned_y, ned_z, ned_qw, ned_qx, ned_qy, ned_qz, vel_x, vel_y, vel_z.
    output logic [255:0] o_m_axis_tdata,
    // vel_updated.
    output logic         o_m_axis_tuser
);

    localparam int PW   = npve_pkg::POS_W;
    localparam int QW   = npve_pkg::QUAT_W;
    localparam int TW   = npve_pkg::TIME_W;
    localparam int NA   = npve_pkg::NUM_AXES;
    localparam int IDXW = $clog2(WINDOW);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_SUM  = 3'd2;
    localparam logic [2:0] S_CMP  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    function automatic logic [PW-1:0] neg_sat32(input logic [PW-1:0] v);
        if (v == {1'b1, {(PW-1){1'b0}}}) begin
            return {1'b0, {(PW-1){1'b1}}};
        end
        return ~v + 1'b1;
    endfunction

    function automatic logic [QW-1:0] neg_sat16(input logic [QW-1:0] v);
        if (v == {1'b1, {(QW-1){1'b0}}}) begin
            return {1'b0, {(QW-1){1'b1}}};
        end
        return ~v + 1'b1;
    endfunction

    logic [2:0]      r_state;
    logic [IDXW-1:0] r_slot;
    logic [PW-1:0]   r_pos [NA];
    logic [QW-1:0]   r_qw, r_qx, r_qy, r_qz;
    logic [npve_pkg::SEC_W-1:0]  r_sec;
    logic [npve_pkg::NSEC_W-1:0] r_nsec;
    logic [TW-1:0]   r_time;
    logic [PW-1:0]   r_old [NA];
    logic [TW-1:0]   r_old_t;
    logic [TW-1:0]   r_dt;
    logic            r_start;
    logic            r_upd;
    logic            r_out_valid;
    logic [255:0]    r_out_data;
    logic            r_out_user;

    logic [PW-1:0]   r_ring_p [WINDOW][NA];
    logic [TW-1:0]   r_ring_t [WINDOW];

    logic [IDXW-1:0] w_nxt;
    logic [npve_pkg::SEC_W+npve_pkg::NSEC_W-1:0] w_sec_ns;
    logic [TW:0]     w_dt;
    logic            w_differ;
    logic            w_later;
    logic            w_load_out;
    logic            w_accept;

    npve_pkg::t_lane_res      w_res [NA];
    logic [PW-1:0]            w_vel [NA];
    logic                     w_fire;

    assign w_nxt    = (r_slot == IDXW'(WINDOW - 1)) ? '0 : r_slot + 1'b1;
    assign w_sec_ns = r_sec * npve_pkg::NS_PER_SEC;
    assign w_dt     = {1'b0, r_time} - {1'b0, r_old_t};
    assign w_later  = !w_dt[TW] && (|w_dt[TW-1:0]);

    always_comb begin
        w_differ = 1'b0;
        for (int k = 0; k < NA; k++) begin
            w_differ = w_differ | (r_pos[k] != r_old[k]);
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_load_out      = (r_state == S_OUT) && (!r_out_valid || i_m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_slot      <= '0;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
            for (int s = 0; s < WINDOW; s++) begin
                r_ring_t[s] <= '0;
                for (int k = 0; k < NA; k++) begin
                    r_ring_p[s][k] <= '0;
                end
            end
        end else begin
            r_start <= 1'b0;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: r_state <= S_SUM;
                S_SUM: r_state <= S_CMP;
                S_CMP: begin
                    r_ring_t[r_slot] <= r_time;
                    for (int k = 0; k < NA; k++) begin
                        r_ring_p[r_slot][k] <= r_pos[k];
                    end
                    r_slot <= w_nxt;
                    if (w_differ && w_later) begin
                        r_start <= 1'b1;
                        r_state <= S_DIV;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_DIV: begin
                    if (w_fire) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_load_out) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pos[0] <= i_s_axis_tdata[31:0];
            r_pos[1] <= neg_sat32(i_s_axis_tdata[63:32]);
            r_pos[2] <= neg_sat32(i_s_axis_tdata[95:64]);
            r_qw     <= i_s_axis_tdata[111:96];
            r_qx     <= i_s_axis_tdata[127:112];
            r_qy     <= neg_sat16(i_s_axis_tdata[143:128]);
            r_qz     <= neg_sat16(i_s_axis_tdata[159:144]);
            r_sec    <= i_s_axis_tdata[191:160];
            r_nsec   <= i_s_axis_tdata[221:192];
        end
        if (r_state == S_MUL) begin
            r_time <= TW'(w_sec_ns);
        end
        if (r_state == S_SUM) begin
            r_time  <= r_time + TW'(r_nsec);
            r_old_t <= r_ring_t[w_nxt];
            for (int k = 0; k < NA; k++) begin
                r_old[k] <= r_ring_p[w_nxt][k];
            end
        end
        if (r_state == S_CMP) begin
            r_dt  <= w_dt[TW-1:0];
            r_upd <= w_differ && w_later;
        end
        if (w_load_out) begin
            r_out_data <= {w_vel[2], w_vel[1], w_vel[0], r_qz, r_qy, r_qx, r_qw,
                           r_pos[2], r_pos[1], r_pos[0]};
            r_out_user <= r_upd;
        end
    end

    for (genvar g = 0; g < NA; g++) begin : g_lane
        npve_vel_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (r_start),
            .i_now   (r_pos[g]),
            .i_old   (r_old[g]),
            .i_dt    (r_dt),
            .o_res   (w_res[g])
        );
    end

    npve_vel_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (w_res),
        .o_vel   (w_vel),
        .o_fire  (w_fire)
    );

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

`ifndef SYNTH
    a_fire_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |-> (r_state == S_DIV))
        else $error("velocity update outside the divide phase");

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot <= IDXW'(WINDOW - 1))
        else $error("ring write slot out of range");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_out_valid && !i_m_axis_tready) |=> (r_state == S_OUT))
        else $error("result left the output stage while the register was full");

    a_start_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_start |-> r_upd)
        else $error("lane start without a velocity update");
`endif

endmodule

@@ hw/rtl/npve_vel_lane.sv @@
// ----------------------------------------------------------------------------
// npve_vel_lane: velocity of one axis
// Forms |new - old| * 1e9, divides it by dt one quotient bit per cycle and
// applies the sign with saturation to the signed 32-bit range.
// ----------------------------------------------------------------------------
module npve_vel_lane (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [npve_pkg::POS_W-1:0]    i_now,
    input  logic [npve_pkg::POS_W-1:0]    i_old,
    input  logic [npve_pkg::TIME_W-1:0]   i_dt,
    output npve_pkg::t_lane_res           o_res
);

    localparam int PW   = npve_pkg::POS_W;
    localparam int TW   = npve_pkg::TIME_W;
    localparam int CNTW = $clog2(TW);
    localparam int PRODW = PW + npve_pkg::NSEC_W;

    localparam logic [1:0] L_IDLE = 2'd0;
    localparam logic [1:0] L_MUL  = 2'd1;
    localparam logic [1:0] L_DIV  = 2'd2;
    localparam logic [1:0] L_SAT  = 2'd3;

    logic [1:0]      r_state, n_state;
    logic [CNTW-1:0] r_cnt, n_cnt;
    logic            r_done, n_done;
    logic            r_neg, n_neg;
    logic [PW-1:0]   r_mag, n_mag;
    logic [TW-1:0]   r_den, n_den;
    logic [TW-1:0]   r_quo, n_quo;
    logic [TW-1:0]   r_rem, n_rem;
    logic [PW-1:0]   r_vel, n_vel;

    logic [PW:0]     w_diff;
    logic [PW:0]     w_abs;
    logic [PRODW-1:0] w_prod;
    logic [TW:0]     w_rem_sh;
    logic [TW:0]     w_rem_sub;
    logic            w_ge;

    assign w_diff    = {i_now[PW-1], i_now} - {i_old[PW-1], i_old};
    assign w_abs     = w_diff[PW] ? (~w_diff + 1'b1) : w_diff;
    assign w_prod    = r_mag * npve_pkg::NS_PER_SEC;
    assign w_rem_sh  = {r_rem, r_quo[TW-1]};
    assign w_rem_sub = w_rem_sh - {1'b0, r_den};
    assign w_ge      = !w_rem_sub[TW];

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        n_neg   = r_neg;
        n_mag   = r_mag;
        n_den   = r_den;
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_vel   = r_vel;
        unique case (r_state)
            L_IDLE: begin
                if (i_start) begin
                    n_neg   = w_diff[PW];
                    n_mag   = w_abs[PW-1:0];
                    n_den   = i_dt;
                    n_state = L_MUL;
                end
            end
            L_MUL: begin
                n_quo   = TW'(w_prod);
                n_rem   = '0;
                n_cnt   = '0;
                n_state = L_DIV;
            end
            L_DIV: begin
                n_rem = w_ge ? w_rem_sub[TW-1:0] : w_rem_sh[TW-1:0];
                n_quo = {r_quo[TW-2:0], w_ge};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNTW'(TW - 1)) begin
                    n_state = L_SAT;
                end
            end
            L_SAT: begin
                if (r_neg) begin
                    if ((|r_quo[TW-1:PW]) || (r_quo[PW-1] && (|r_quo[PW-2:0]))) begin
                        n_vel = {1'b1, {(PW-1){1'b0}}};
                    end else begin
                        n_vel = ~r_quo[PW-1:0] + 1'b1;
                    end
                end else begin
                    if (|r_quo[TW-1:PW-1]) begin
                        n_vel = {1'b0, {(PW-1){1'b1}}};
                    end else begin
                        n_vel = r_quo[PW-1:0];
                    end
                end
                n_done  = 1'b1;
                n_state = L_IDLE;
            end
            default: n_state = L_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_cnt   <= n_cnt;
        end
        r_neg <= n_neg;
        r_mag <= n_mag;
        r_den <= n_den;
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_vel <= n_vel;
    end

    assign o_res.done = r_done;
    assign o_res.vel  = r_vel;

endmodule

@@ hw/rtl/npve_vel_merge.sv @@
// ----------------------------------------------------------------------------
// npve_vel_merge: held velocity vector
// Loads the three lane results together once every lane has finished and
// flags the update in the cycle after the lanes finish, with the new vector.
// ----------------------------------------------------------------------------
module npve_vel_merge (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  npve_pkg::t_lane_res           i_res [npve_pkg::NUM_AXES],
    output logic [npve_pkg::POS_W-1:0]    o_vel [npve_pkg::NUM_AXES],
    output logic                          o_fire
);

    logic [npve_pkg::POS_W-1:0] r_vel [npve_pkg::NUM_AXES];
    logic                       r_fire;
    logic                       w_all_done;

    always_comb begin
        w_all_done = 1'b1;
        for (int k = 0; k < npve_pkg::NUM_AXES; k++) begin
            w_all_done = w_all_done & i_res[k].done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fire <= 1'b0;
            for (int k = 0; k < npve_pkg::NUM_AXES; k++) begin
                r_vel[k] <= '0;
            end
        end else begin
            r_fire <= w_all_done;
            if (w_all_done) begin
                for (int k = 0; k < npve_pkg::NUM_AXES; k++) begin
                    r_vel[k] <= i_res[k].vel;
                end
            end
        end
    end

    assign o_vel  = r_vel;
    assign o_fire = r_fire;

endmodule
